FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL of the header parser.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define AST_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/akhp_pkg.sv
// ---------------------------------------------------------------------------
// AX.25 KISS header parser package
// Role and verdict codes, protocol constants and the classifier result type.
// ---------------------------------------------------------------------------
package akhp_pkg;

	// Octets in one AX.25 address field.
	localparam int unsigned ADDR_OCTETS = 7;
	localparam logic [2:0]  LAST_OCTET  = 3'(ADDR_OCTETS - 1);

	// Protocol constants.
	localparam logic [3:0] KISS_PORT_MASK = 4'hf;
	localparam int unsigned ADDR_END_BIT  = 0;
	localparam int unsigned REPEATED_BIT  = 7;
	localparam logic [7:0] CTL_UI         = 8'h03;
	localparam logic [7:0] PID_NO_LAYER3  = 8'hf0;

	// Role of one byte within the frame.
	typedef enum logic [2:0] {
		ROLE_KISS = 3'd0,
		ROLE_DEST = 3'd1,
		ROLE_SRC  = 3'd2,
		ROLE_RPT  = 3'd3,
		ROLE_CTL  = 3'd4,
		ROLE_PID  = 3'd5,
		ROLE_PAY  = 3'd6,
		ROLE_REJ  = 3'd7
	} role_t;

	// Frame verdict.
	typedef enum logic [1:0] {
		VERDICT_INVALID      = 2'd0,
		VERDICT_VALID        = 2'd1,
		VERDICT_VALID_UNUSED = 2'd2
	} verdict_t;

	// Classification of one byte, handed from the classifier to the top level.
	typedef struct packed {
		role_t       role;
		logic [2:0]  slot;
		logic [2:0]  pos;
		logic        verdict_here;
		verdict_t    verdict;
		logic [3:0]  rpt_count;
		logic [3:0]  next_rpt;
	} class_t;

endpackage

FILE: rtl/akhp_classify.sv
// ---------------------------------------------------------------------------
// AX.25 KISS header byte classifier
// Holds the per-frame parse state and labels the byte presented to it.
// The state advances only when the byte moves into the result register.
// ---------------------------------------------------------------------------
module akhp_classify #(
	parameter int unsigned MAX_REPEATERS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic [7:0]      data_byte,
	input  logic            frame_end,
	output akhp_pkg::class_t res
);
	import akhp_pkg::*;

	typedef enum logic [2:0] {
		PH_KISS = 3'd0,
		PH_DEST = 3'd1,
		PH_SRC  = 3'd2,
		PH_RPT  = 3'd3,
		PH_CTL  = 3'd4,
		PH_PID  = 3'd5,
		PH_PAY  = 3'd6,
		PH_REJ  = 3'd7
	} phase_t;

	localparam logic [3:0] RPT_MAX = 4'(MAX_REPEATERS);

	phase_t     phase_q, phase_upd;
	logic [2:0] octet_q, octet_upd;
	logic [3:0] rpt_seen_q, rpt_seen_upd;
	logic [3:0] next_unused_q, next_unused_upd;
	logic       ctl_ok_q, ctl_ok_upd;
	logic       verdict_given_q;
	logic       last_octet;

	assign last_octet = (octet_q >= LAST_OCTET);

	// Classify the current byte and work out the state after it.
	always_comb begin
		phase_upd       = phase_q;
		octet_upd       = octet_q;
		rpt_seen_upd    = rpt_seen_q;
		next_unused_upd = next_unused_q;
		ctl_ok_upd      = ctl_ok_q;
		res.role         = ROLE_KISS;
		res.slot         = 3'd0;
		res.pos          = 3'd0;
		res.verdict_here = 1'b0;
		res.verdict      = VERDICT_INVALID;
		case (phase_q)
			PH_KISS: begin
				if ((data_byte[3:0] & KISS_PORT_MASK) != 4'd0) begin
					res.role  = ROLE_REJ;
					phase_upd = PH_REJ;
				end else begin
					res.role  = ROLE_KISS;
					phase_upd = PH_DEST;
					octet_upd = 3'd0;
				end
			end
			PH_DEST: begin
				res.role = ROLE_DEST;
				res.pos  = octet_q;
				if (last_octet) begin
					octet_upd = 3'd0;
					phase_upd = PH_SRC;
				end else begin
					octet_upd = octet_q + 3'd1;
				end
			end
			PH_SRC: begin
				res.role = ROLE_SRC;
				res.pos  = octet_q;
				if (last_octet) begin
					octet_upd = 3'd0;
					if (frame_end) begin
						res.verdict_here = 1'b1;
						res.verdict      = VERDICT_VALID;
					end
					phase_upd = data_byte[ADDR_END_BIT] ? PH_CTL : PH_RPT;
				end else begin
					octet_upd = octet_q + 3'd1;
				end
			end
			PH_RPT: begin
				res.role = ROLE_RPT;
				res.slot = rpt_seen_q[2:0];
				res.pos  = octet_q;
				if (last_octet) begin
					octet_upd = 3'd0;
					if (data_byte[REPEATED_BIT]) begin
						next_unused_upd = rpt_seen_q + 4'd1;
					end
					if (rpt_seen_q < RPT_MAX) begin
						rpt_seen_upd = rpt_seen_q + 4'd1;
					end
					if (data_byte[ADDR_END_BIT] || (rpt_seen_upd >= RPT_MAX)) begin
						phase_upd = PH_CTL;
					end
				end else begin
					octet_upd = octet_q + 3'd1;
				end
			end
			PH_CTL: begin
				res.role   = ROLE_CTL;
				ctl_ok_upd = (data_byte == CTL_UI);
				phase_upd  = PH_PID;
			end
			PH_PID: begin
				res.role         = ROLE_PID;
				res.verdict_here = 1'b1;
				if (ctl_ok_q && (data_byte == PID_NO_LAYER3)) begin
					res.verdict = ((rpt_seen_q == 4'd0) || (next_unused_q >= rpt_seen_q))
						? VERDICT_VALID : VERDICT_VALID_UNUSED;
				end else begin
					res.verdict = VERDICT_INVALID;
				end
				phase_upd = PH_PAY;
			end
			PH_PAY: begin
				res.role = ROLE_PAY;
			end
			PH_REJ: begin
				res.role = ROLE_REJ;
			end
			default: begin
				res.role = ROLE_REJ;
			end
		endcase
		// A frame that ends without a verdict so far is invalid.
		if (frame_end && !res.verdict_here && !verdict_given_q) begin
			res.verdict_here = 1'b1;
			res.verdict      = VERDICT_INVALID;
		end
		res.rpt_count = rpt_seen_upd;
		res.next_rpt  = next_unused_upd;
	end

	// Parse state; every frame end returns it to the reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_KISS;
			octet_q         <= 3'd0;
			rpt_seen_q      <= 4'd0;
			next_unused_q   <= 4'd0;
			ctl_ok_q        <= 1'b0;
			verdict_given_q <= 1'b0;
		end else if (advance) begin
			if (frame_end) begin
				phase_q         <= PH_KISS;
				octet_q         <= 3'd0;
				rpt_seen_q      <= 4'd0;
				next_unused_q   <= 4'd0;
				ctl_ok_q        <= 1'b0;
				verdict_given_q <= 1'b0;
			end else begin
				phase_q         <= phase_upd;
				octet_q         <= octet_upd;
				rpt_seen_q      <= rpt_seen_upd;
				next_unused_q   <= next_unused_upd;
				ctl_ok_q        <= ctl_ok_upd;
				verdict_given_q <= verdict_given_q | res.verdict_here;
			end
		end
	end

endmodule

FILE: rtl/ax25_kiss_header_parser_top.sv
// ---------------------------------------------------------------------------
// AX.25 KISS header parser, top level
// Labels each byte of a KISS data frame by its role in the AX.25 UI header
// and gives one verdict per frame.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, data_byte, frame_end) takes one
//   byte of a KISS frame per item, with frame_end high on the last byte.
//   The output channel (out_valid, out_stall and the result fields) returns
//   one item per input item, in order, with the byte passed through.
//   An accepted item goes into the input register, is classified there and
//   is written to the result register when that register frees, and is then
//   offered on the output; out_stall can hold it in the input register.
//   Throughput: one item per cycle while out_stall is low. The input
//   register and the result register are both kept full while the receiver
//   takes items, so the rate is set only by the output side.
//   When out_stall is high with a result waiting, the result holds, the
//   byte in the input register waits, and in_stall rises once that register
//   is occupied.
//   Reset empties both registers and returns the parse state to the start of
//   a frame; the block can take a new frame as soon as reset is released.
//   A verdict appears once per frame: on the PID byte, or on the last byte
//   if the frame ends earlier.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ax25_kiss_header_parser_top #(
	parameter int unsigned MAX_REPEATERS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       frame_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] byte_out,
	output logic [2:0] role,
	output logic [2:0] repeater_slot,
	output logic [2:0] octet_pos,
	output logic       verdict_here,
	output logic [1:0] verdict,
	output logic [3:0] repeater_count,
	output logic [3:0] next_repeater,
	output logic       last_of_frame
);
	import akhp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       out_valid_q;
	logic       advance;
	logic       fire;
	logic       in_accept;
	class_t     res;

	// Handshake: the result register frees when empty or when taken.
	assign advance   = !out_valid_q || !out_stall;
	assign fire      = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= data_byte;
			end_s1  <= frame_end;
		end
	end

	// Byte classifier and parse state.
	akhp_classify #(
		.MAX_REPEATERS(MAX_REPEATERS)
	) u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (fire),
		.data_byte (byte_s1),
		.frame_end (end_s1),
		.res       (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			byte_out       <= byte_s1;
			role           <= res.role;
			repeater_slot  <= res.slot;
			octet_pos      <= res.pos;
			verdict_here   <= res.verdict_here;
			verdict        <= res.verdict;
			repeater_count <= res.rpt_count;
			next_repeater  <= res.next_rpt;
			last_of_frame  <= end_s1;
		end
	end

	// Checks on the internal pipeline and on the result labels.
	`AST_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !advance, valid_s1 && $stable(byte_s1) && $stable(end_s1), "input register lost a waiting item")
	`AST_IMPLIES(a_slot_only_rpt, clk, arst_n, out_valid_q && (role != ROLE_RPT), repeater_slot == 3'd0, "repeater slot set outside a repeater octet")
	`AST_IMPLIES(a_good_verdict_place, clk, arst_n, out_valid_q && verdict_here && (verdict != VERDICT_INVALID), (role == ROLE_SRC) || (role == ROLE_PID), "valid verdict outside source end or PID byte")

endmodule
